FILE: hdl/oss_pkg.sv
// oss_pkg: shared constants, function codes and types for the ordered selection set
// used by oss_mem, oss_ctrl and ordered_selection_set
package oss_pkg;

    localparam int CAPACITY = 64;
    localparam int HANDLE_W = 32;
    localparam int FUNC_W   = 3;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 80;

    localparam logic [FUNC_W-1:0] FN_REPLACE = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD     = 3'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_TOGGLE  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_READ    = 3'd5;
    localparam logic [FUNC_W-1:0] FN_QUERY   = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SETPRI  = 3'd7;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [HANDLE_W-1:0] wdata;
        logic [ADDR_W-1:0]   raddr;
    } mem_req_t;

    typedef struct packed {
        logic                dropped;
        logic [HANDLE_W-1:0] read_handle;
        logic                was_member;
        logic [HANDLE_W-1:0] primary_handle;
        logic [COUNT_W-1:0]  member_count;
    } result_t;

endpackage

FILE: hdl/oss_mem.sv
// oss_mem: member store, one write port and one registered read port
// depends on oss_pkg for depth, widths and the request struct
module oss_mem (
    input  logic                         clk,
    input  oss_pkg::mem_req_t            req,
    output logic [oss_pkg::HANDLE_W-1:0] rdata
);

    logic [oss_pkg::HANDLE_W-1:0] mem [oss_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

FILE: hdl/oss_ctrl.sv
// oss_ctrl: sequencer that walks the member store for search, compaction and reads
// depends on oss_pkg; drives oss_mem through a mem_req_t
module oss_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [oss_pkg::FUNC_W-1:0]   func,
    input  logic [oss_pkg::HANDLE_W-1:0] sel_handle,
    input  logic [oss_pkg::INDEX_W-1:0]  index,
    output oss_pkg::mem_req_t            mem_req,
    input  logic [oss_pkg::HANDLE_W-1:0] mem_rdata,
    output logic                         res_valid,
    input  logic                         res_take,
    output oss_pkg::result_t             res
);

    localparam int CW = oss_pkg::CNT_W;
    localparam int AW = oss_pkg::ADDR_W;
    localparam int HW = oss_pkg::HANDLE_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(oss_pkg::CAPACITY);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_FIX    = 3'd4;
    localparam logic [2:0] ST_PRI    = 3'd5;
    localparam logic [2:0] ST_READ   = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]                  state_reg, state_next;
    logic [oss_pkg::FUNC_W-1:0]  func_reg, func_next;
    logic [HW-1:0]               handle_reg, handle_next;
    logic [oss_pkg::INDEX_W-1:0] idx_reg, idx_next;
    logic [CW-1:0]               total_reg, total_next;
    logic [HW-1:0]               primary_reg, primary_next;
    logic                        member_reg, member_next;
    logic                        drop_reg, drop_next;
    logic [HW-1:0]               readv_reg, readv_next;
    logic [CW-1:0]               ptr_reg, ptr_next;
    logic                        pend_reg, pend_next;
    logic [CW-1:0]               lag_reg, lag_next;

    logic [31:0] idx_ext;
    logic [31:0] total_ext;
    logic        idx_in_range;

    assign idx_ext      = {{(32 - oss_pkg::INDEX_W){1'b0}}, idx_reg};
    assign total_ext    = {{(32 - CW){1'b0}}, total_reg};
    assign idx_in_range = idx_ext < total_ext;

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb
    begin
        res.member_count   = total_ext[oss_pkg::COUNT_W-1:0];
        res.primary_handle = primary_reg;
        res.was_member     = member_reg;
        res.read_handle    = readv_reg;
        res.dropped        = drop_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        func_next    = func_reg;
        handle_next  = handle_reg;
        idx_next     = idx_reg;
        total_next   = total_reg;
        primary_next = primary_reg;
        member_next  = member_reg;
        drop_next    = drop_reg;
        readv_next   = readv_reg;
        ptr_next     = ptr_reg;
        pend_next    = pend_reg;
        lag_next     = lag_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = '0;
        mem_req.wdata = '0;
        mem_req.raddr = ptr_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next   = func;
                    handle_next = sel_handle;
                    idx_next    = index;
                    member_next = 1'b0;
                    drop_next   = 1'b0;
                    readv_next  = '0;
                    ptr_next    = '0;
                    pend_next   = 1'b0;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                // one read issued per cycle, compared against the handle once the registered read data returns
                if (pend_reg && (mem_rdata == handle_reg))
                begin
                    member_next = 1'b1;
                    state_next  = ST_EXEC;
                end
                else if (ptr_reg < total_reg)
                begin
                    pend_next = 1'b1;
                    lag_next  = ptr_reg;
                    ptr_next  = ptr_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = ST_EXEC;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                unique case (func_reg)
                    oss_pkg::FN_REPLACE:
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = '0;
                        mem_req.wdata = handle_reg;
                        total_next    = CW'(1);
                        primary_next  = handle_reg;
                    end
                    oss_pkg::FN_ADD, oss_pkg::FN_REMOVE, oss_pkg::FN_TOGGLE:
                    begin
                        if (member_reg && (func_reg != oss_pkg::FN_ADD))
                        begin
                            // lag_reg holds the match position
                            ptr_next   = lag_reg + CW'(1);
                            pend_next  = 1'b0;
                            state_next = ST_SHIFT;
                        end
                        else if (!member_reg && (func_reg != oss_pkg::FN_REMOVE))
                        begin
                            if (total_reg == CAP_CNT)
                            begin
                                drop_next = 1'b1;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = total_reg[AW-1:0];
                                mem_req.wdata = handle_reg;
                                total_next    = total_reg + CW'(1);
                                if (primary_reg == '0)
                                begin
                                    primary_next = handle_reg;
                                end
                            end
                        end
                    end
                    oss_pkg::FN_CLEAR:
                    begin
                        total_next   = '0;
                        primary_next = '0;
                    end
                    oss_pkg::FN_READ:
                    begin
                        if (idx_in_range)
                        begin
                            mem_req.raddr = idx_ext[AW-1:0];
                            state_next    = ST_READ;
                        end
                    end
                    oss_pkg::FN_QUERY:
                    begin
                    end
                    oss_pkg::FN_SETPRI:
                    begin
                        primary_next = handle_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SHIFT:
            begin
                // read entry ptr, write it one slot down on the next cycle
                if (pend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = lag_reg[AW-1:0];
                    mem_req.wdata = mem_rdata;
                end
                if (ptr_reg < total_reg)
                begin
                    pend_next = 1'b1;
                    lag_next  = ptr_reg - CW'(1);
                    ptr_next  = ptr_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = ST_FIX;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            ST_FIX:
            begin
                mem_req.raddr = '0;
                total_next    = total_reg - CW'(1);
                state_next    = ST_PRI;
            end
            ST_PRI:
            begin
                if ((primary_reg == handle_reg) && (total_reg != '0))
                begin
                    primary_next = mem_rdata;
                end
                state_next = ST_DONE;
            end
            ST_READ:
            begin
                readv_next = mem_rdata;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            primary_reg <= '0;
            pend_reg    <= 1'b0;
            ptr_reg     <= '0;
            lag_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            primary_reg <= primary_next;
            pend_reg    <= pend_next;
            ptr_reg     <= ptr_next;
            lag_reg     <= lag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        handle_reg <= handle_next;
        idx_reg    <= idx_next;
        member_reg <= member_next;
        drop_reg   <= drop_next;
        readv_reg  <= readv_next;
    end

`ifndef SYNTH
    a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CAP_CNT)
        else $error("member total above capacity");

    a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && drop_reg |-> total_reg == CAP_CNT)
        else $error("drop reported with room left");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (state_reg == ST_EXEC) || (state_reg == ST_SHIFT))
        else $error("store written outside exec or shift");

    a_shift_below_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) && pend_reg |-> lag_reg < total_reg)
        else $error("compaction write beyond member total");

    a_fix_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIX) |-> total_reg != '0)
        else $error("remove on empty set");
`endif

endmodule

FILE: hdl/ordered_selection_set.sv
// ordered_selection_set: insertion-ordered handle set with a primary handle
// each transaction: a search of the store that stops at a hit, exec, then result handoff;
// a read adds a registered store read, removal of a member adds shift, fix and primary steps
// throughput: one transaction at a time, as oss_ctrl accepts input only while idle
// the output register lets the next transaction enter while a result waits
// reset: async active low, count and primary cleared, store contents left undefined
module ordered_selection_set (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // func[2:0], sel_handle[34:3], index[40:35], zero fill
    input  logic [oss_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // member_count[6:0], primary_handle[38:7], was_member[39],
    // read_handle[71:40], dropped[72], zero fill
    output logic [oss_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int RW = $bits(oss_pkg::result_t);

    oss_pkg::mem_req_t            mem_req;
    logic [oss_pkg::HANDLE_W-1:0] mem_rdata;
    logic                         res_valid;
    logic                         res_take;
    oss_pkg::result_t             res;
    oss_pkg::result_t             out_reg;
    logic                         out_valid_reg, out_valid_next;

    oss_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    oss_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .func       (s_tdata[2:0]),
        .sel_handle (s_tdata[34:3]),
        .index      (s_tdata[40:35]),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res)
    );

    assign res_take = res_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(oss_pkg::OUT_DATA_W - RW){1'b0}}, out_reg};

endmodule

FILE: bench/ordered_selection_set_checker.sv
// ordered_selection_set_checker: tracks the handle set from accepted input transactions,
// predicts each result and compares it field by field with the output stream
// depends on oss_pkg for widths, function codes and the result layout
`timescale 1ns / 1ps

module ordered_selection_set_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // func[2:0], sel_handle[34:3], index[40:35], zero fill
    input  logic [oss_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // member_count[6:0], primary_handle[38:7], was_member[39],
    // read_handle[71:40], dropped[72], zero fill
    input  logic [oss_pkg::OUT_DATA_W-1:0] m_tdata,
    output int                             fail_count,
    output int                             pending
);

    localparam int HW = oss_pkg::HANDLE_W;
    localparam int FW = oss_pkg::FUNC_W;
    localparam int IW = oss_pkg::INDEX_W;

    logic [HW-1:0]     set_members [oss_pkg::CAPACITY];
    int                set_size;
    logic [HW-1:0]     primary_q;
    oss_pkg::result_t  expected_results [$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic int locate_handle(logic [HW-1:0] h);
        for (int i = 0; i < set_size; i++)
            if (set_members[i] == h)
                return i;
        return -1;
    endfunction

    // returns 1 when the set is full and the handle is refused
    function automatic logic insert_handle(logic [HW-1:0] h);
        if (locate_handle(h) >= 0)
            return 1'b0;
        if (set_size >= oss_pkg::CAPACITY)
            return 1'b1;
        set_members[set_size] = h;
        set_size++;
        if (primary_q == '0)
            primary_q = h;
        return 1'b0;
    endfunction

    function automatic void delete_handle(logic [HW-1:0] h);
        int pos;
        pos = locate_handle(h);
        if (pos < 0)
            return;
        for (int i = pos; i + 1 < set_size; i++)
            set_members[i] = set_members[i + 1];
        set_size--;
        // primary moves to the head only while something is left
        if (primary_q == h && set_size > 0)
            primary_q = set_members[0];
    endfunction

    function automatic oss_pkg::result_t predict_selection(logic [FW-1:0] fn,
                                                           logic [HW-1:0] h,
                                                           logic [IW-1:0] idx);
        oss_pkg::result_t r;
        logic             hit;
        r   = '0;
        hit = (locate_handle(h) >= 0);
        case (fn)
            oss_pkg::FN_REPLACE:
            begin
                set_members[0] = h;
                set_size       = 1;
                primary_q      = h;
            end
            oss_pkg::FN_ADD:    r.dropped = insert_handle(h);
            oss_pkg::FN_REMOVE: delete_handle(h);
            oss_pkg::FN_TOGGLE:
            begin
                if (hit)
                    delete_handle(h);
                else
                    r.dropped = insert_handle(h);
            end
            oss_pkg::FN_CLEAR:
            begin
                set_size  = 0;
                primary_q = '0;
            end
            oss_pkg::FN_READ:
            begin
                if (int'(idx) < set_size)
                    r.read_handle = set_members[idx];
            end
            oss_pkg::FN_QUERY:  ;
            default:            primary_q = h;
        endcase
        r.member_count   = set_size[oss_pkg::COUNT_W-1:0];
        r.primary_handle = primary_q;
        r.was_member     = hit;
        return r;
    endfunction

    task automatic check_field(string name, logic [HW-1:0] want, logic [HW-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        oss_pkg::result_t want;
        oss_pkg::result_t got;
        if (!rst_n)
        begin
            set_size  = 0;
            primary_q = '0;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_selection(
                    s_tdata[FW-1:0],
                    s_tdata[FW +: HW],
                    s_tdata[FW + HW +: IW]));
            if (m_tvalid && m_tready)
            begin
                got = oss_pkg::result_t'(m_tdata[$bits(oss_pkg::result_t)-1:0]);
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("member_count", HW'(want.member_count),
                                HW'(got.member_count));
                    check_field("primary_handle", want.primary_handle, got.primary_handle);
                    check_field("was_member", HW'(want.was_member), HW'(got.was_member));
                    check_field("read_handle", want.read_handle, got.read_handle);
                    check_field("dropped", HW'(want.dropped), HW'(got.dropped));
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

FILE: bench/ordered_selection_set_tb.sv
// ordered_selection_set_tb: drives directed and random set operations with random
// gaps and output stalls, and reports the verdict from the checker
// depends on oss_pkg, ordered_selection_set and ordered_selection_set_checker
`timescale 1ns / 1ps

module ordered_selection_set_tb;

    localparam int HW = oss_pkg::HANDLE_W;
    localparam int FW = oss_pkg::FUNC_W;
    localparam int IW = oss_pkg::INDEX_W;

    // random phases run until the total reaches this, the last phase overshoots a little
    localparam int ITEM_TARGET = 1005;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    // func[2:0], sel_handle[34:3], index[40:35], zero fill
    logic [oss_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    // member_count[6:0], primary_handle[38:7], was_member[39],
    // read_handle[71:40], dropped[72], zero fill
    logic [oss_pkg::OUT_DATA_W-1:0] m_tdata;
    int                             fail_count;
    int                             pending;

    int                             items_sent;
    logic                           sender_gaps_on;
    logic [HW-1:0]                  handle_pool [16];

    ordered_selection_set dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ordered_selection_set_checker result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("ordered_selection_set verification failed");
        $finish;
    end

    // receiver: ready runs and stalls, mostly short, a few long
    initial
    begin
        int run;
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            m_tready <= 1'b1;
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 6);
            repeat (run - 1) @(negedge clk);
            case ($urandom_range(0, 9))
                0:       stall = $urandom_range(10, 60);
                1, 2:    stall = 0;
                default: stall = $urandom_range(1, 3);
            endcase
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    function automatic int sender_gap();
        int r;
        if (!sender_gaps_on)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 19)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [HW-1:0] pick_handle();
        if ($urandom_range(0, 99) < 65)
            return handle_pool[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    function automatic logic [IW-1:0] rand_index();
        return IW'($urandom_range(0, 63));
    endfunction

    function automatic logic [FW-1:0] pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)  return oss_pkg::FN_REPLACE;
        if (r < 32) return oss_pkg::FN_ADD;
        if (r < 46) return oss_pkg::FN_REMOVE;
        if (r < 60) return oss_pkg::FN_TOGGLE;
        if (r < 63) return oss_pkg::FN_CLEAR;
        if (r < 80) return oss_pkg::FN_READ;
        if (r < 90) return oss_pkg::FN_QUERY;
        return oss_pkg::FN_SETPRI;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic issue_op(logic [FW-1:0] fn, logic [HW-1:0] h, logic [IW-1:0] idx);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(oss_pkg::IN_DATA_W - FW - HW - IW){1'b0}}, idx, h, fn};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // hold off the sender until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    task automatic refresh_pool();
        handle_pool[0] = '0;
        handle_pool[1] = '1;
        for (int i = 2; i < 16; i++)
            handle_pool[i] = $urandom;
    endtask

    task automatic mixed_phase();
        int n;
        n = $urandom_range(40, 90);
        refresh_pool();
        repeat (n)
            issue_op(pick_func(), pick_handle(), rand_index());
    endtask

    // grow the set to capacity, push past it, then work on a full set
    task automatic fill_phase();
        logic [HW-1:0] filled [$];
        logic [HW-1:0] h;
        int            adds;
        int            k;
        refresh_pool();
        issue_op(oss_pkg::FN_REPLACE, pick_handle(), rand_index());
        adds = 0;
        while (adds < oss_pkg::CAPACITY + 1)
        begin
            if ($urandom_range(0, 5) == 0)
                issue_op(oss_pkg::FN_READ, pick_handle(), rand_index());
            else
            begin
                h = $urandom;
                issue_op(oss_pkg::FN_ADD, h, rand_index());
                filled.push_back(h);
                adds++;
            end
        end
        issue_op(oss_pkg::FN_TOGGLE, $urandom, rand_index());
        issue_op(oss_pkg::FN_ADD, filled[$urandom_range(0, 20)], rand_index());
        repeat ($urandom_range(6, 16))
        begin
            k = $urandom_range(0, filled.size() - 1);
            case ($urandom_range(0, 5))
                0:       issue_op(oss_pkg::FN_REMOVE, filled[k], rand_index());
                1:       issue_op(oss_pkg::FN_TOGGLE, filled[k], rand_index());
                2:       issue_op(oss_pkg::FN_QUERY, filled[k], rand_index());
                3:       issue_op(oss_pkg::FN_SETPRI, filled[k], rand_index());
                4:       issue_op(oss_pkg::FN_ADD, $urandom, rand_index());
                default: issue_op(oss_pkg::FN_READ, filled[k], rand_index());
            endcase
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        items_sent     = 0;
        sender_gaps_on = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty set reads, handle zero, primary rules, compaction and clear
        issue_op(oss_pkg::FN_READ,    32'h0000_0000, 6'd0);
        issue_op(oss_pkg::FN_QUERY,   32'h0000_0000, 6'd63);
        issue_op(oss_pkg::FN_ADD,     32'h0000_0000, 6'd0);
        issue_op(oss_pkg::FN_ADD,     32'h0000_0000, 6'd0);
        issue_op(oss_pkg::FN_ADD,     32'hFFFF_FFFF, 6'd63);
        issue_op(oss_pkg::FN_ADD,     32'h1234_5678, 6'd0);
        issue_op(oss_pkg::FN_READ,    32'h0000_0000, 6'd2);
        issue_op(oss_pkg::FN_READ,    32'hFFFF_FFFF, 6'd63);
        issue_op(oss_pkg::FN_QUERY,   32'h1234_5678, 6'd0);
        issue_op(oss_pkg::FN_REMOVE,  32'h0000_0005, 6'd0);
        issue_op(oss_pkg::FN_REMOVE,  32'hFFFF_FFFF, 6'd0);
        issue_op(oss_pkg::FN_SETPRI,  32'hDEAD_BEEF, 6'd0);
        issue_op(oss_pkg::FN_TOGGLE,  32'h0000_0000, 6'd0);
        issue_op(oss_pkg::FN_TOGGLE,  32'h0000_0000, 6'd0);
        issue_op(oss_pkg::FN_READ,    32'h0000_0000, 6'd1);
        issue_op(oss_pkg::FN_CLEAR,   32'h0000_0000, 6'd0);
        issue_op(oss_pkg::FN_REPLACE, 32'hA5A5_A5A5, 6'd0);
        issue_op(oss_pkg::FN_REMOVE,  32'hA5A5_A5A5, 6'd0);
        issue_op(oss_pkg::FN_ADD,     32'h5A5A_5A5A, 6'd0);
        issue_op(oss_pkg::FN_SETPRI,  32'h0000_0000, 6'd0);
        issue_op(oss_pkg::FN_ADD,     32'h8000_0001, 6'd0);
        issue_op(oss_pkg::FN_REPLACE, 32'hFFFF_FFFF, 6'd0);
        issue_op(oss_pkg::FN_READ,    32'h0000_0000, 6'd0);
        issue_op(oss_pkg::FN_CLEAR,   32'hFFFF_FFFF, 6'd63);
        drain_results();

        while (items_sent < ITEM_TARGET)
        begin
            sender_gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0)
                fill_phase();
            else
                mixed_phase();
            if ($urandom_range(0, 3) == 0)
                drain_results();
        end

        drain_results();
        repeat (2 * oss_pkg::CAPACITY + 10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ordered_selection_set verification clean");
        else
            $display("ordered_selection_set verification failed");
        $finish;
    end

endmodule
